// File: sv/cmm_pkg.sv
// Shared types and constants for the complex matrix multiply unit.
// Used by the top level and by its port checker; no dependencies.
package cmm_pkg;

  // Fixed field widths of the stream items
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 5;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  // Register port
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 4;

  // Item operation codes; code 3 is ignored
  typedef enum logic [OP_W-1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_READ    = 2'd2
  } op_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_SAT   = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Register indexes (word address)
  typedef enum logic [1:0] {
    REG_A_ROWS = 2'd0,
    REG_INNER  = 2'd1,
    REG_B_COLS = 2'd2
  } reg_idx_t;

endpackage

// File: sv/complex_matrix_multiply_unit.sv
// Complex matrix multiply unit: element stores for A and B, one complex MAC datapath.
// Depends on cmm_pkg.
//
// Write items (operation 0 or 1) load one complex element of A or B; they leave the
// block idle and produce no result. A read item (operation 2) returns element
// (row, col) of C = A x B: the block issues one read of each store per cycle, since
// the single read port of each store feeds one complex multiply-accumulate per cycle.
// The reads pass through the read, product and term registers into the accumulator;
// the sum is then rounded and loaded into the output register. A read with an index
// outside the configured sizes, or while a size exceeds MAX_DIM, loads status 2. One
// item is processed at a time; the output register lets a finished result wait while
// the next item is taken. Stores are not cleared at reset: read only elements that
// were written. Registers (word address): 0 a_row_count, 1 inner_count, 2 b_col_count,
// 5 bits each, reset value 2.
module complex_matrix_multiply_unit #(
  parameter int MAX_DIM    = 16,
  parameter int ELEM_WIDTH = 16,
  parameter int FRAC_BITS  = 14,
  localparam int TD_W = ((2 * cmm_pkg::IDX_W + 2 * ELEM_WIDTH + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst,
  // input items
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [TD_W-1:0]              s_tdata,  // row_index, col_index, real_part, imag_part
  input  logic [cmm_pkg::OP_W-1:0]     s_tuser,  // operation
  // result items
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [TD_W-1:0]              m_tdata,  // out_row, out_col, out_real, out_imag
  output logic [cmm_pkg::STAT_W-1:0]   m_tuser,  // status
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cmm_pkg::CFG_AW-1:0]   paddr,
  input  logic [cmm_pkg::CFG_DW-1:0]   pwdata,
  output logic [cmm_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready
);
  import cmm_pkg::*;

  localparam int EW     = ELEM_WIDTH;
  localparam int PW     = 2 * EW;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int AW     = $clog2(DEPTH);
  localparam int MW     = 2 * $clog2(MAX_DIM) + IDX_W + 1;
  localparam int KW     = $clog2(MAX_DIM + 1);
  localparam int CMP_W  = (KW > CNT_W) ? KW : CNT_W;
  localparam int SUM_W  = 2 * EW + 2 + $clog2(MAX_DIM);
  localparam int ACC_W  = (SUM_W > EW + FRAC_BITS + 1) ? SUM_W : EW + FRAC_BITS + 1;
  localparam int SH_W   = ACC_W - FRAC_BITS;

  localparam logic signed [ACC_W-1:0] HALF =
    {{(ACC_W - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
  localparam logic signed [EW-1:0] EMAX = {1'b0, {(EW - 1){1'b1}}};
  localparam logic signed [EW-1:0] EMIN = {1'b1, {(EW - 1){1'b0}}};

  typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_DRAIN, S_ROUND, S_FINISH} state_t;

  // input item fields
  logic [IDX_W-1:0]     in_row, in_col;
  logic [EW-1:0]        in_re, in_im;
  op_t                  in_op;
  logic                 in_fire;

  assign in_row  = s_tdata[IDX_W-1:0];
  assign in_col  = s_tdata[2*IDX_W-1:IDX_W];
  assign in_re   = s_tdata[2*IDX_W+EW-1:2*IDX_W];
  assign in_im   = s_tdata[2*IDX_W+2*EW-1:2*IDX_W+EW];
  assign in_op   = op_t'(s_tuser);
  assign in_fire = s_tvalid && s_tready;

  // registers
  logic [CNT_W-1:0] a_rows, inner, b_cols;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= CNT_W'(2);
      inner  <= CNT_W'(2);
      b_cols <= CNT_W'(2);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_A_ROWS: a_rows <= pwdata[CNT_W-1:0];
        REG_INNER:  inner  <= pwdata[CNT_W-1:0];
        REG_B_COLS: b_cols <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_A_ROWS: prdata = CFG_DW'(a_rows);
      REG_INNER:  prdata = CFG_DW'(inner);
      REG_B_COLS: prdata = CFG_DW'(b_cols);
      default:    prdata = '0;
    endcase
  end

  // control state
  state_t              state;
  logic [IDX_W-1:0]    row_q, col_q;
  logic [KW-1:0]       k;
  logic                k_done;
  logic                err_q;
  logic                mem_vld, prod_vld, term_vld;
  logic                rd_en;
  logic                bad_read;

  assign s_tready = (state == S_IDLE);
  assign k_done   = (CMP_W'(k) == CMP_W'(inner));
  assign rd_en    = (state == S_ISSUE) && !k_done;

  // range check of a read request
  assign bad_read = (CMP_W'(a_rows) > CMP_W'(MAX_DIM)) ||
                    (CMP_W'(inner) > CMP_W'(MAX_DIM)) ||
                    (CMP_W'(b_cols) > CMP_W'(MAX_DIM)) ||
                    (CNT_W'(in_row) >= a_rows) || (CNT_W'(in_col) >= b_cols);

  // element stores: real part low, imaginary part high
  logic [PW-1:0] left_mem  [DEPTH];
  logic [PW-1:0] right_mem [DEPTH];
  logic [PW-1:0] a_q, b_q;
  logic          wr_ok, wr_a, wr_b;
  logic [AW-1:0] w_addr, a_raddr, b_raddr;

  assign wr_ok   = (in_row < MAX_DIM) && (in_col < MAX_DIM);
  assign wr_a    = in_fire && (in_op == OP_WRITE_A) && wr_ok;
  assign wr_b    = in_fire && (in_op == OP_WRITE_B) && wr_ok;
  assign w_addr  = AW'(MW'(in_row) * MW'(MAX_DIM) + MW'(in_col));
  assign a_raddr = AW'(MW'(row_q) * MW'(MAX_DIM) + MW'(k));
  assign b_raddr = AW'(MW'(k) * MW'(MAX_DIM) + MW'(col_q));

  always_ff @(posedge clk) begin
    if (wr_a) left_mem[w_addr] <= {in_im, in_re};
  end

  always_ff @(posedge clk) begin
    if (wr_b) right_mem[w_addr] <= {in_im, in_re};
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      a_q <= left_mem[a_raddr];
      b_q <= right_mem[b_raddr];
    end
  end

  // product stage, then term stage
  logic signed [EW-1:0]    ar, ai, br, bi;
  logic signed [PW-1:0]    p_rr, p_ii, p_ri, p_ir;
  logic signed [ACC_W-1:0] t_re, t_im;

  assign ar = signed'(a_q[EW-1:0]);
  assign ai = signed'(a_q[PW-1:EW]);
  assign br = signed'(b_q[EW-1:0]);
  assign bi = signed'(b_q[PW-1:EW]);

  always_ff @(posedge clk) begin
    if (mem_vld) begin
      p_rr <= ar * br;
      p_ii <= ai * bi;
      p_ri <= ar * bi;
      p_ir <= ai * br;
    end
    if (prod_vld) begin
      t_re <= ACC_W'(p_rr) - ACC_W'(p_ii);
      t_im <= ACC_W'(p_ri) + ACC_W'(p_ir);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld  <= 1'b0;
      prod_vld <= 1'b0;
      term_vld <= 1'b0;
    end else begin
      mem_vld  <= rd_en;
      prod_vld <= mem_vld;
      term_vld <= prod_vld;
    end
  end

  // rounding and clamp
  logic signed [ACC_W-1:0] acc_re, acc_im, rnd_re, rnd_im;
  logic signed [SH_W-1:0]  sh_re, sh_im;
  logic                    ovf_re, ovf_im;
  logic signed [EW-1:0]    res_re, res_im;

  assign rnd_re = acc_re + HALF;
  assign rnd_im = acc_im + HALF;
  assign ovf_re = (sh_re[SH_W-1:EW-1] != '0) && (sh_re[SH_W-1:EW-1] != '1);
  assign ovf_im = (sh_im[SH_W-1:EW-1] != '0) && (sh_im[SH_W-1:EW-1] != '1);
  assign res_re = ovf_re ? (sh_re[SH_W-1] ? EMIN : EMAX) : sh_re[EW-1:0];
  assign res_im = ovf_im ? (sh_im[SH_W-1] ? EMIN : EMAX) : sh_im[EW-1:0];

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      k        <= '0;
      err_q    <= 1'b0;
    end else begin
      if (m_tready && state != S_FINISH) m_tvalid <= 1'b0;
      if (term_vld) begin
        acc_re <= acc_re + t_re;
        acc_im <= acc_im + t_im;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire && in_op == OP_READ) begin
            row_q  <= in_row;
            col_q  <= in_col;
            k      <= '0;
            acc_re <= '0;
            acc_im <= '0;
            err_q  <= bad_read;
            state  <= bad_read ? S_FINISH : S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (k_done) state <= S_DRAIN;
          else k <= k + KW'(1);
        end
        S_DRAIN: begin
          if (!mem_vld && !prod_vld && !term_vld) state <= S_ROUND;
        end
        S_ROUND: begin
          sh_re <= rnd_re[ACC_W-1:FRAC_BITS];
          sh_im <= rnd_im[ACC_W-1:FRAC_BITS];
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            if (err_q) begin
              m_tdata <= TD_W'({{(2 * EW){1'b0}}, col_q, row_q});
              m_tuser <= ST_RANGE;
            end else begin
              m_tdata <= TD_W'({res_im, res_re, col_q, row_q});
              m_tuser <= (ovf_re || ovf_im) ? ST_SAT : ST_OK;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/cmm_checker.sv
// Port-level checks for the complex matrix multiply unit, bound to its top level.
// Depends on cmm_pkg and complex_matrix_multiply_unit.
module cmm_port_checks #(
  parameter int ELEM_WIDTH = 16,
  localparam int TD_W = ((2 * cmm_pkg::IDX_W + 2 * ELEM_WIDTH + 7) / 8) * 8
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic [TD_W-1:0]            s_tdata,
  input logic [cmm_pkg::OP_W-1:0]   s_tuser,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [TD_W-1:0]            m_tdata,
  input logic [cmm_pkg::STAT_W-1:0] m_tuser
);
  import cmm_pkg::*;

  logic in_fire;
  assign in_fire = s_tvalid && s_tready;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // a range error carries zero parts
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_RANGE |->
      m_tdata[2*IDX_W+2*ELEM_WIDTH-1:2*IDX_W] == '0)
    else $error("range error with nonzero data");

  // a store write or an ignored item never creates a result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && in_fire && s_tuser != OP_READ |=> !m_tvalid)
    else $error("result after a write item");

  // a read occupies the datapath
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire && s_tuser == OP_READ |=> !s_tready)
    else $error("input taken right after a read");

endmodule

bind complex_matrix_multiply_unit cmm_port_checks #(.ELEM_WIDTH(ELEM_WIDTH)) u_cmm_checker (.*);
